/* hdl/byte_stuffed_frame_receiver_unit_assert.svh */
// Assertion macros used by the frame receiver control module.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property outside reset.
`define BSFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property that also covers the reset cycles.
`define BSFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSFR_ASSERT(lbl, prop, msg)
`define BSFR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* hdl/bsfr_pkg.sv */
// Types, constants and the CRC step for the byte-stuffed frame receiver.
package bsfr_pkg;

  localparam int STORE_DEPTH_DEF = 64;

  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd3;

  // Register reset values
  localparam logic [7:0] START_RST  = 8'h02;
  localparam logic [7:0] END_RST    = 8'h03;
  localparam logic [7:0] ESCAPE_RST = 8'h1B;
  localparam logic [7:0] MASK_RST   = 8'h20;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame size limits: smallest checked frame, and header plus CRC with no payload
  localparam int MIN_FRAME   = 3;
  localparam int EMPTY_FRAME = 4;
  localparam int FIRST_PAY   = 2;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_CRC = 2'd1,
    STAT_OVF = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Fold one byte into a reflected CRC-16
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* hdl/bsfr_frame_mem.sv */
// Frame store: single-port write, registered read.
module bsfr_frame_mem #(
  parameter int STORE_DEPTH = bsfr_pkg::STORE_DEPTH_DEF,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic               clk,
  input  bsfr_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]      wr_addr,
  input  logic [7:0]         wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  // Write one stored byte
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold data between reads
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/bsfr_ctl.sv */
// Frame receiver control: unstuffing, CRC, result sequencing and config registers.
`include "byte_stuffed_frame_receiver_unit_assert.svh"

module bsfr_ctl #(
  parameter int STORE_DEPTH = bsfr_pkg::STORE_DEPTH_DEF,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [2:0]                     out_command,
  output logic [2:0]                     out_data_kind,
  output logic [1:0]                     out_sequence_res,
  output logic [7:0]                     out_length_field,
  output logic [7:0]                     out_payload_byte,
  output logic                           out_payload_valid,
  output logic                           out_last,
  output bsfr_pkg::mem_ctl_t             mem_ctl,
  output logic [AW-1:0]                  mem_wr_addr,
  output logic [7:0]                     mem_wr_data,
  output logic [AW-1:0]                  mem_rd_addr,
  input  logic [7:0]                     mem_rd_data
);

  // Config registers
  logic [7:0] start_r, end_r, escb_r, mask_r;

  // Control state
  bsfr_pkg::state_t  state_r, state_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic              esc_r, esc_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]     last_idx_r, last_idx_nxt;
  bsfr_pkg::status_t res_status_r, res_status_nxt;
  logic              pay_valid_r, pay_valid_nxt;
  logic              res_last_r, res_last_nxt;

  // Payload-side registers
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  hist0_r, hist0_nxt;
  logic [7:0]  hist1_r, hist1_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  flags_r, flags_nxt;

  logic       in_acc, out_acc;
  logic       do_store, emit, go_drain;
  logic [7:0] byte_x, store_b;
  logic       res_ok;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign byte_x  = esc_r ? (in_rx_byte ^ mask_r) : in_rx_byte;

  // Write config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= bsfr_pkg::START_RST;
      end_r   <= bsfr_pkg::END_RST;
      escb_r  <= bsfr_pkg::ESCAPE_RST;
      mask_r  <= bsfr_pkg::MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsfr_pkg::REG_START:  start_r <= cfg_data;
        bsfr_pkg::REG_END:    end_r   <= cfg_data;
        bsfr_pkg::REG_ESCAPE: escb_r  <= cfg_data;
        bsfr_pkg::REG_MASK:   mask_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the incoming word and update frame state
  always_comb begin
    in_frame_nxt   = in_frame_r;
    esc_nxt        = esc_r;
    cnt_nxt        = cnt_r;
    crc_nxt        = crc_r;
    hist0_nxt      = hist0_r;
    hist1_nxt      = hist1_r;
    len_nxt        = len_r;
    flags_nxt      = flags_r;
    rd_idx_nxt     = rd_idx_r;
    last_idx_nxt   = last_idx_r;
    res_status_nxt = res_status_r;
    pay_valid_nxt  = pay_valid_r;
    res_last_nxt   = res_last_r;
    do_store       = 1'b0;
    emit           = 1'b0;
    go_drain       = 1'b0;
    store_b        = byte_x;

    if (in_acc) begin
      if (!in_frame_r) begin
        // Open a frame on the start word, drop anything else
        if (in_rx_byte == start_r) begin
          in_frame_nxt = 1'b1;
          esc_nxt      = 1'b0;
          cnt_nxt      = '0;
          crc_nxt      = bsfr_pkg::CRC_INIT;
        end
      end else if (!esc_r && in_rx_byte == escb_r) begin
        esc_nxt = 1'b1;
      end else if (!esc_r && in_rx_byte == end_r) begin
        // Close the frame and check it
        in_frame_nxt = 1'b0;
        if (cnt_r >= AW'(bsfr_pkg::MIN_FRAME)) begin
          emit          = 1'b1;
          res_last_nxt  = 1'b1;
          pay_valid_nxt = 1'b0;
          if ({hist0_r, hist1_r} != crc_r) begin
            res_status_nxt = bsfr_pkg::STAT_CRC;
          end else begin
            res_status_nxt = bsfr_pkg::STAT_OK;
            if (cnt_r > AW'(bsfr_pkg::EMPTY_FRAME)) begin
              emit          = 1'b0;
              go_drain      = 1'b1;
              pay_valid_nxt = 1'b1;
              rd_idx_nxt    = AW'(bsfr_pkg::FIRST_PAY);
              last_idx_nxt  = cnt_r - AW'(bsfr_pkg::MIN_FRAME);
            end
          end
        end
      end else begin
        // Store a plain or unescaped word, or drop the frame on overflow
        esc_nxt = 1'b0;
        if (cnt_r != AW'(STORE_DEPTH - 1)) begin
          do_store  = 1'b1;
          cnt_nxt   = cnt_r + AW'(1);
          hist1_nxt = hist0_r;
          hist0_nxt = store_b;
          if (cnt_r >= AW'(bsfr_pkg::FIRST_PAY)) begin
            crc_nxt = bsfr_pkg::crc_fold(crc_r, hist1_r);
          end
          if (cnt_r == AW'(0)) begin
            len_nxt = store_b;
          end
          if (cnt_r == AW'(1)) begin
            flags_nxt = store_b;
          end
        end else begin
          in_frame_nxt   = 1'b0;
          emit           = 1'b1;
          res_status_nxt = bsfr_pkg::STAT_OVF;
          pay_valid_nxt  = 1'b0;
          res_last_nxt   = 1'b1;
        end
      end
    end

    // Advance the payload drain
    if (state_r == bsfr_pkg::ST_READ) begin
      res_last_nxt = (rd_idx_r == last_idx_r);
    end
    if (state_r == bsfr_pkg::ST_SEND && out_acc && !res_last_r) begin
      rd_idx_nxt = rd_idx_r + AW'(1);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsfr_pkg::ST_RUN: begin
        if (go_drain) begin
          state_nxt = bsfr_pkg::ST_READ;
        end else if (emit) begin
          state_nxt = bsfr_pkg::ST_SEND;
        end
      end
      bsfr_pkg::ST_READ: state_nxt = bsfr_pkg::ST_SEND;
      bsfr_pkg::ST_SEND: begin
        if (out_acc) begin
          state_nxt = res_last_r ? bsfr_pkg::ST_RUN : bsfr_pkg::ST_READ;
        end
      end
      default: state_nxt = bsfr_pkg::ST_RUN;
    endcase
  end

  // Handshake and memory outputs
  always_comb begin
    in_stall      = (state_r != bsfr_pkg::ST_RUN);
    out_valid     = (state_r == bsfr_pkg::ST_SEND);
    mem_ctl.wr_en = do_store;
    mem_ctl.rd_en = (state_r == bsfr_pkg::ST_READ);
    mem_wr_addr   = cnt_r;
    mem_wr_data   = store_b;
    mem_rd_addr   = rd_idx_r;
  end

  // Result fields; error results carry zeros
  assign res_ok            = (res_status_r == bsfr_pkg::STAT_OK);
  assign out_status        = res_status_r;
  assign out_command       = res_ok ? flags_r[7:5] : 3'd0;
  assign out_data_kind     = res_ok ? flags_r[4:2] : 3'd0;
  assign out_sequence_res  = res_ok ? flags_r[1:0] : 2'd0;
  assign out_length_field  = res_ok ? len_r : 8'd0;
  assign out_payload_byte  = pay_valid_r ? mem_rd_data : 8'd0;
  assign out_payload_valid = pay_valid_r;
  assign out_last          = res_last_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bsfr_pkg::ST_RUN;
      in_frame_r   <= 1'b0;
      esc_r        <= 1'b0;
      cnt_r        <= '0;
      crc_r        <= bsfr_pkg::CRC_INIT;
      rd_idx_r     <= '0;
      last_idx_r   <= '0;
      res_status_r <= bsfr_pkg::STAT_OK;
      pay_valid_r  <= 1'b0;
      res_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_frame_r   <= in_frame_nxt;
      esc_r        <= esc_nxt;
      cnt_r        <= cnt_nxt;
      crc_r        <= crc_nxt;
      rd_idx_r     <= rd_idx_nxt;
      last_idx_r   <= last_idx_nxt;
      res_status_r <= res_status_nxt;
      pay_valid_r  <= pay_valid_nxt;
      res_last_r   <= res_last_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hist0_r <= hist0_nxt;
    hist1_r <= hist1_nxt;
    len_r   <= len_nxt;
    flags_r <= flags_nxt;
  end

  `BSFR_ASSERT_RST(a_reset_run, (!rst_n) |=> (state_r == bsfr_pkg::ST_RUN), "not in run state after reset")
  `BSFR_ASSERT(a_send_after_read, (state_r == bsfr_pkg::ST_SEND && pay_valid_r && !$past(state_r == bsfr_pkg::ST_SEND)) |-> $past(state_r == bsfr_pkg::ST_READ), "payload sent without memory read")
  `BSFR_ASSERT(a_idx_bound, (state_r != bsfr_pkg::ST_RUN && pay_valid_r) |-> (rd_idx_r <= last_idx_r), "drain index past last payload byte")
  `BSFR_ASSERT(a_last_ends, (out_valid && !out_stall && out_last) |=> (state_r == bsfr_pkg::ST_RUN), "drain continues after last word")
  `BSFR_ASSERT(a_wr_only_run, mem_ctl.wr_en |-> (state_r == bsfr_pkg::ST_RUN && in_valid), "store written outside input accept")

endmodule

/* hdl/byte_stuffed_frame_receiver_unit.sv */
// Byte-stuffed frame receiver: deframes, unescapes and CRC-checks serial bytes.
//
// Input channel: in_valid/in_stall carry one raw received byte per word.
// Result channel: out_valid/out_stall carry status, header fields and payload.
// Config channel: cfg_valid/cfg_ready write start, end, escape and mask registers
// by index 0..3; other indexes are ignored. cfg_ready is always high.
// Input bytes are taken while in_stall is low. A store overflow or CRC error gives one
// status word the cycle after the offending byte; a good frame without payload
// likewise gives one word. A good frame with payload drains its payload from the
// frame store: each payload word is a store read (ST_READ) and then an output
// word (ST_SEND), which is held for as long as out_stall is high.
// in_stall is high while results are pending, so no byte is taken during a drain.
// Reset restores the register defaults and clears the frame state; the store
// itself is not cleared, and nothing reads an entry not written in the frame.
// A stalled result word holds until it is taken.
module byte_stuffed_frame_receiver_unit #(
  parameter int STORE_DEPTH = bsfr_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [2:0]                     out_command,
  output logic [2:0]                     out_data_kind,
  output logic [1:0]                     out_sequence_res,
  output logic [7:0]                     out_length_field,
  output logic [7:0]                     out_payload_byte,
  output logic                           out_payload_valid,
  output logic                           out_last
);

  localparam int AW = $clog2(STORE_DEPTH);

  bsfr_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
  logic [7:0]         mem_wr_data, mem_rd_data;

  // Sequencer and datapath
  bsfr_ctl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_command      (out_command),
    .out_data_kind    (out_data_kind),
    .out_sequence_res (out_sequence_res),
    .out_length_field (out_length_field),
    .out_payload_byte (out_payload_byte),
    .out_payload_valid(out_payload_valid),
    .out_last         (out_last),
    .mem_ctl          (mem_ctl),
    .mem_wr_addr      (mem_wr_addr),
    .mem_wr_data      (mem_wr_data),
    .mem_rd_addr      (mem_rd_addr),
    .mem_rd_data      (mem_rd_data)
  );

  // Frame store
  bsfr_frame_mem #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_mem (
    .clk    (clk),
    .ctl    (mem_ctl),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule

/* dv/frame_receiver_sb_pkg.sv */
// Scoreboard for the frame receiver: expected-word predictor and result checker.
package frame_receiver_sb_pkg;
  import bsfr_pkg::*;

  // One result word as seen on the out_ ports
  typedef struct {
    status_t    status;
    logic [2:0] command;
    logic [2:0] data_kind;
    logic [1:0] sequence_res;
    logic [7:0] length_field;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       last;
  } frame_word_t;

  class frame_scoreboard;
    logic [7:0]  start_code;
    logic [7:0]  end_code;
    logic [7:0]  escape_code;
    logic [7:0]  escape_xor;
    bit          open;
    bit          escaped;
    int          fill;
    logic [7:0]  held_bytes[STORE_DEPTH_DEF];
    logic [15:0] frame_crc;
    frame_word_t expected_words[$];
    int unsigned mismatches;

    function new();
      start_code  = START_RST;
      end_code    = END_RST;
      escape_code = ESCAPE_RST;
      escape_xor  = MASK_RST;
      open        = 0;
      escaped     = 0;
      fill        = 0;
      frame_crc   = CRC_INIT;
      mismatches  = 0;
    endfunction

    // Reflected CRC-16, one data bit at a time
    static function logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ b[k];
        c = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    // Update a register copy; unknown indexes are dropped
    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
      case (idx)
        REG_START:  start_code  = val;
        REG_END:    end_code    = val;
        REG_ESCAPE: escape_code = val;
        REG_MASK:   escape_xor  = val;
        default: ;
      endcase
    endfunction

    function void push_word(input status_t st, input logic [7:0] flags, input logic [7:0] len,
                            input logic [7:0] pay, input logic pv, input logic lst);
      frame_word_t w;
      w.status        = st;
      w.command       = flags[7:5];
      w.data_kind     = flags[4:2];
      w.sequence_res  = flags[1:0];
      w.length_field  = len;
      w.payload_byte  = pay;
      w.payload_valid = pv;
      w.last          = lst;
      expected_words.push_back(w);
    endfunction

    // Advance the deframer by one accepted byte and queue the words it causes
    function void note_byte(input logic [7:0] raw);
      logic [7:0]  b;
      logic [15:0] rx_crc;
      int          n;
      b = raw;
      if (!open) begin
        if (b == start_code) begin
          open      = 1;
          fill      = 0;
          escaped   = 0;
          frame_crc = CRC_INIT;
        end
        return;
      end
      if (escaped) begin
        b       = b ^ escape_xor;
        escaped = 0;
      end else if (b == escape_code) begin
        escaped = 1;
        return;
      end else if (b == end_code) begin
        open = 0;
        n    = fill;
        // drop short frames silently
        if (n < MIN_FRAME) return;
        rx_crc = {held_bytes[n-1], held_bytes[n-2]};
        if (rx_crc != frame_crc) begin
          push_word(STAT_CRC, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
          return;
        end
        if (n <= EMPTY_FRAME) begin
          push_word(STAT_OK, held_bytes[1], held_bytes[0], 8'h00, 1'b0, 1'b1);
          return;
        end
        for (int i = FIRST_PAY; i < n - 2; i++)
          push_word(STAT_OK, held_bytes[1], held_bytes[0], held_bytes[i], 1'b1, i == n - 3);
        return;
      end
      // store the byte, folding in the one two places back
      if (fill < STORE_DEPTH_DEF - 1) begin
        if (fill >= 2) frame_crc = crc_step(frame_crc, held_bytes[fill-2]);
        held_bytes[fill] = b;
        fill++;
      end else begin
        open = 0;
        push_word(STAT_OVF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted word with the oldest expectation
    function void check_word(input frame_word_t got);
      frame_word_t want;
      if (expected_words.size() == 0) begin
        $error("word with no expectation: status %0d payload_byte %0d",
               got.status, got.payload_byte);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("command", 8'(want.command), 8'(got.command));
      compare_field("data_kind", 8'(want.data_kind), 8'(got.data_kind));
      compare_field("sequence_res", 8'(want.sequence_res), 8'(got.sequence_res));
      compare_field("length_field", want.length_field, got.length_field);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

endpackage

/* dv/byte_stuffed_frame_receiver_unit_tb.sv */
// Testbench top for the byte-stuffed frame receiver: stimulus, idling and final verdict.
module byte_stuffed_frame_receiver_unit_tb;
  import bsfr_pkg::*;
  import frame_receiver_sb_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_BYTES   = 8;
  // Index outside the register map, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_status;
  logic [2:0]           out_command;
  logic [2:0]           out_data_kind;
  logic [1:0]           out_sequence_res;
  logic [7:0]           out_length_field;
  logic [7:0]           out_payload_byte;
  logic                 out_payload_valid;
  logic                 out_last;

  frame_scoreboard sb;
  int              idle_pct;
  int              stall_pct;
  bit              calm;
  bit              hold_req;
  int              bytes_sent;
  int              cycle_count;
  logic [7:0]      frame_body[$];
  logic [7:0]      frame_wire[$];

  byte_stuffed_frame_receiver_unit #(
    .STORE_DEPTH(STORE_DEPTH_DEF)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_command(out_command),
    .out_data_kind(out_data_kind),
    .out_sequence_res(out_sequence_res),
    .out_length_field(out_length_field),
    .out_payload_byte(out_payload_byte),
    .out_payload_valid(out_payload_valid),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int burst;
    burst     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 0;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        burst = $urandom_range(1, 12) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    frame_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      w.status        = status_t'(out_status);
      w.command       = out_command;
      w.data_kind     = out_data_kind;
      w.sequence_res  = out_sequence_res;
      w.length_field  = out_length_field;
      w.payload_byte  = out_payload_byte;
      w.payload_valid = out_payload_valid;
      w.last          = out_last;
      sb.check_word(w);
    end
  end

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one word, with an optional gap first, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!calm && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_wire();
    foreach (frame_wire[i]) send_byte(frame_wire[i]);
  endtask

  // Escape end and escape codes; escape other bytes now and then too
  task automatic add_stuffed(input logic [7:0] d);
    if (d == sb.end_code || d == sb.escape_code || $urandom_range(11) == 0) begin
      frame_wire.push_back(sb.escape_code);
      frame_wire.push_back(d ^ sb.escape_xor);
    end else begin
      frame_wire.push_back(d);
    end
  endtask

  // Wrap frame_body with start, CRC and end, and send it
  task automatic send_frame(input bit bad_crc);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_body[i]) c = frame_scoreboard::crc_step(c, frame_body[i]);
    if (bad_crc) c = c ^ 16'(1 << $urandom_range(15));
    frame_wire.delete();
    frame_wire.push_back(sb.start_code);
    foreach (frame_body[i]) add_stuffed(frame_body[i]);
    add_stuffed(c[7:0]);
    add_stuffed(c[15:8]);
    frame_wire.push_back(sb.end_code);
    send_wire();
  endtask

  // Random byte, biased toward the framing codes and the extremes
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(5) == 0) begin
      case ($urandom_range(5))
        0: b = sb.start_code;
        1: b = sb.end_code;
        2: b = sb.escape_code;
        3: b = sb.escape_xor;
        4: b = 8'h00;
        default: b = 8'hFF;
      endcase
    end
    return b;
  endfunction

  task automatic build_body(input int pay_len);
    frame_body.delete();
    frame_body.push_back(($urandom_range(7) == 0) ? pick_byte() : 8'(pay_len));
    frame_body.push_back(pick_byte());
    repeat (pay_len) frame_body.push_back(pick_byte());
  endtask

  // Line noise, mostly without start codes, then two end codes to close any stray frame
  task automatic send_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      b = 8'($urandom);
      if (b == sb.start_code && $urandom_range(1)) b = ~b;
      send_byte(b);
    end
    send_byte(sb.end_code);
    send_byte(sb.end_code);
  endtask

  // Stop offering and wait for every expected word, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reroll_idling();
    if (!calm && $urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 35;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 35;
      endcase
    end
  endtask

  // Mostly good frames, with bad CRCs, short, overflowing and cut-off frames and noise
  task automatic random_traffic(input int count);
    int goal;
    int kind;
    goal = bytes_sent + count;
    while (bytes_sent < goal) begin
      reroll_idling();
      kind = $urandom_range(99);
      if (kind < 60) begin
        build_body(($urandom_range(24) == 0) ? $urandom_range(40, 59) : $urandom_range(0, 10));
        send_frame(1'b0);
      end else if (kind < 72) begin
        build_body($urandom_range(0, 8));
        send_frame(1'b1);
      end else if (kind < 80) begin
        if ($urandom_range(2) == 0) begin
          frame_body.delete();
          frame_body.push_back(pick_byte());
          send_frame($urandom_range(3) == 0);
        end else begin
          frame_wire.delete();
          frame_wire.push_back(sb.start_code);
          repeat ($urandom_range(1)) add_stuffed(pick_byte());
          frame_wire.push_back(sb.end_code);
          send_wire();
        end
      end else if (kind < 85) begin
        build_body($urandom_range(60, 62));
        send_frame(1'b0);
      end else if (kind < 92) begin
        frame_wire.delete();
        frame_wire.push_back(sb.start_code);
        repeat ($urandom_range(1, 6)) add_stuffed(pick_byte());
        send_wire();
        build_body($urandom_range(0, 6));
        send_frame(1'b0);
      end else begin
        send_noise($urandom_range(1, 8));
      end
    end
  endtask

  // Load a framing setup; the first two are the extremes
  task automatic configure(input int phase);
    logic [7:0] s, e, x, m;
    case (phase)
      1: begin s = 8'h00; e = 8'hFF; x = 8'h80; m = 8'hFF; end
      2: begin s = 8'hFF; e = 8'h00; x = 8'h7E; m = 8'h00; end
      default: begin
        s = 8'($urandom);
        do e = 8'($urandom); while (e == s);
        do x = 8'($urandom); while (x == s || x == e);
        m = 8'($urandom);
      end
    endcase
    program_reg(REG_START, s);
    program_reg(REG_END, e);
    program_reg(REG_ESCAPE, x);
    program_reg(REG_MASK, m);
    if (phase == 2) program_reg(REG_SPARE, 8'hFF);
  endtask

  task automatic directed_frames();
    idle_pct  = 10;
    stall_pct = 10;
    // bytes outside a frame are ignored
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sb.end_code);
    send_byte(sb.escape_code);
    // short frames: nothing, one byte, CRC only
    frame_wire = {sb.start_code, sb.end_code};
    send_wire();
    frame_wire = {sb.start_code, 8'h55, sb.end_code};
    send_wire();
    frame_body.delete();
    send_frame(1'b0);
    // three-byte frame: flags double as the CRC low byte
    frame_body = {8'hA5};
    send_frame(1'b0);
    // empty payload, then header and payload extremes
    frame_body = {8'h00, 8'hFF};
    send_frame(1'b0);
    frame_body = {8'hFF, 8'h00, 8'hFF, 8'h00};
    send_frame(1'b0);
    // framing codes as data, escaped where needed
    frame_body = {8'h05, 8'hE3, sb.start_code, sb.end_code, sb.escape_code,
                  sb.escape_xor, 8'h7F};
    send_frame(1'b0);
    frame_body = {8'h02, 8'h41, 8'h11, 8'h22};
    send_frame(1'b1);
    // the first size that overflows the store
    build_body(60);
    send_frame(1'b0);
    settle();
    // long receiver hold-off while frames keep coming
    hold_req = 1;
    repeat (3) begin
      build_body(2);
      send_frame(1'b0);
    end
    settle();
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_START;
    cfg_data    = 8'h00;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    idle_pct    = 0;
    stall_pct   = 0;
    calm        = 0;
    hold_req    = 0;
    bytes_sent  = 0;
    cycle_count = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    directed_frames();
    random_traffic(PHASE_BYTES);
    settle();
    for (int phase = 1; phase <= 4; phase++) begin
      configure(phase);
      // no idling in the closing phase
      if (phase == 4) begin
        calm      = 1;
        idle_pct  = 0;
        stall_pct = 0;
      end
      random_traffic(PHASE_BYTES);
      settle();
    end

    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* byte_stuffed_frame_receiver_unit.f */
+incdir+hdl
hdl/bsfr_pkg.sv
hdl/bsfr_frame_mem.sv
hdl/bsfr_ctl.sv
hdl/byte_stuffed_frame_receiver_unit.sv
dv/frame_receiver_sb_pkg.sv
dv/byte_stuffed_frame_receiver_unit_tb.sv
